[rtl/mrpt_pkg.sv]
`default_nettype none
package mrpt_pkg;

   // Width of the candidate field on the request channel
   localparam int unsigned CAND_WIDTH = 63;

   // Number of entries in the fixed witness table
   localparam int unsigned BASE_COUNT = 12;

   // Witness bases 2 .. 37
   function automatic logic [5:0] base_of(input logic [3:0] idx);
      logic [5:0] b;
      case (idx)
         4'd0:    b = 6'd2;
         4'd1:    b = 6'd3;
         4'd2:    b = 6'd5;
         4'd3:    b = 6'd7;
         4'd4:    b = 6'd11;
         4'd5:    b = 6'd13;
         4'd6:    b = 6'd17;
         4'd7:    b = 6'd19;
         4'd8:    b = 6'd23;
         4'd9:    b = 6'd29;
         4'd10:   b = 6'd31;
         4'd11:   b = 6'd37;
         default: b = 6'd2;
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

[rtl/mrpt_req_if.sv]
`default_nettype none
interface mrpt_req_if;
   logic                                valid;
   logic                                ready;
   logic [mrpt_pkg::CAND_WIDTH-1:0]     candidate;

   modport source (output valid, output candidate, input ready);
   modport sink   (input valid, input candidate, output ready);
endinterface
`default_nettype wire

[rtl/mrpt_rsp_if.sv]
`default_nettype none
interface mrpt_rsp_if;
   logic valid;
   logic ready;
   logic prime_flag;

   modport source (output valid, output prime_flag, input ready);
   modport sink   (input valid, input prime_flag, output ready);
endinterface
`default_nettype wire

[rtl/mrpt_cell.sv]
`default_nettype none
// One shift-add step of a modular product: acc = (2*acc + bit*a) mod n
module mrpt_cell #(
   parameter int unsigned W = 63
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   input  wire logic [W-1:0] in_acc,
   input  wire logic [W-1:0] in_a,
   input  wire logic [W-1:0] in_b,
   input  wire logic [W-1:0] n,
   output logic              out_valid,
   output logic [W-1:0]      out_acc,
   output logic [W-1:0]      out_a,
   output logic [W-1:0]      out_b
);

   logic         valid_ff;
   logic [W-1:0] acc_ff, a_ff, b_ff;
   logic [W:0]   dbl, sum;
   logic [W-1:0] dbl_red, acc_in;

   always_comb begin
      dbl     = {in_acc, 1'b0};
      dbl_red = (dbl >= {1'b0, n}) ? W'(dbl - {1'b0, n}) : dbl[W-1:0];
      sum     = {1'b0, dbl_red} + {1'b0, in_a};
      if (in_b[W-1]) begin
         acc_in = (sum >= {1'b0, n}) ? W'(sum - {1'b0, n}) : sum[W-1:0];
      end else begin
         acc_in = dbl_red;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      acc_ff <= acc_in;
      a_ff   <= in_a;
      b_ff   <= {in_b[W-2:0], 1'b0};
   end

   assign out_valid = valid_ff;
   assign out_acc   = acc_ff;
   assign out_a     = a_ff;
   assign out_b     = b_ff;

endmodule
`default_nettype wire

[rtl/mrpt_mul_chain.sv]
`default_nettype none
// Row of W cells; cell i consumes multiplier bit W-1-i, result leaves the last cell
module mrpt_mul_chain #(
   parameter int unsigned W = 63
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [W-1:0] op_a,
   input  wire logic [W-1:0] op_b,
   input  wire logic [W-1:0] n,
   output logic              done,
   output logic [W-1:0]      product
);

   logic         v   [W+1];
   logic [W-1:0] acc [W+1];
   logic [W-1:0] a   [W+1];
   logic [W-1:0] b   [W+1];

   assign v[0]   = start;
   assign acc[0] = '0;
   assign a[0]   = op_a;
   assign b[0]   = op_b;

   for (genvar g = 0; g < W; g++) begin : g_cell
      mrpt_cell #(.W(W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (v[g]),
         .in_acc    (acc[g]),
         .in_a      (a[g]),
         .in_b      (b[g]),
         .n         (n),
         .out_valid (v[g+1]),
         .out_acc   (acc[g+1]),
         .out_a     (a[g+1]),
         .out_b     (b[g+1])
      );
   end

   assign done    = v[W];
   assign product = acc[W];

endmodule
`default_nettype wire

[rtl/miller_rabin_prime_test.sv]
`default_nettype none
// Deterministic Miller-Rabin primality test. One transaction on req_if carries a
// candidate; its low NUM_WIDTH bits are tested and one transaction on rsp_if returns
// prime_flag. Zero, one, two and even numbers are settled in the idle state and go
// straight to the output stage without any modular product.
// Odd candidates run a strong-probable-prime check against the first NUM_BASES of the
// bases 2..37 (a base equal to the candidate is skipped). All modular products go
// through a row of NUM_WIDTH shift-add cells, one multiplier bit per cell, and only
// one product is in flight. One candidate is worked on at a time; req_if.ready is
// high only while the block is idle, and a finished result waits in an output
// register until rsp_if.ready takes it.
module miller_rabin_prime_test #(
   parameter int unsigned NUM_WIDTH = 63,
   parameter int unsigned NUM_BASES = 12
) (
   input  wire logic   clock,
   input  wire logic   reset,
   mrpt_req_if.sink    req_if,
   mrpt_rsp_if.source  rsp_if
);

   localparam int unsigned W  = NUM_WIDTH;
   localparam int unsigned RW = $clog2(NUM_WIDTH);
   localparam int unsigned IW = (NUM_BASES > 1) ? $clog2(NUM_BASES) : 1;

   typedef enum logic [3:0] {
      IDLE, SPLIT, BASE_SEL, REDUCE, POW_STEP, POW_ACC_WAIT, POW_SQ_WAIT,
      CHECK, SQ_CHECK, SQ_WAIT, DONE
   } state_type;

   state_type     state_ff;
   logic [W-1:0]  n_ff, nm1_ff, d_ff, e_ff, acc_ff, sq_ff, x_ff;
   logic [W-1:0]  mul_a_ff, mul_b_ff;
   logic          mul_start_ff;
   logic [RW-1:0] r_ff, k_ff;
   logic [IW-1:0] i_ff;
   logic          res_ff;
   logic          rsp_valid_ff, rsp_prime_ff;

   logic [W-1:0]  cand_n, base_w, product;
   logic          mul_done, last_base;

   assign cand_n    = req_if.candidate[W-1:0];
   assign base_w    = W'(mrpt_pkg::base_of(4'(i_ff)));
   assign last_base = (i_ff == IW'(NUM_BASES - 1));

   assign req_if.ready      = (state_ff == IDLE);
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.prime_flag = rsp_prime_ff;

   mrpt_mul_chain #(.W(W)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .op_a    (mul_a_ff),
      .op_b    (mul_b_ff),
      .n       (n_ff),
      .done    (mul_done),
      .product (product)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         mul_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mul_start_ff <= 1'b0;
         // drop the result once it is taken, unless a new one replaces it
         if (rsp_valid_ff && rsp_if.ready && state_ff != DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (req_if.valid) begin
                  n_ff   <= cand_n;
                  nm1_ff <= cand_n - W'(1);
                  d_ff   <= cand_n - W'(1);
                  r_ff   <= '0;
                  i_ff   <= '0;
                  // settle trivial cases at once
                  if (cand_n < W'(2)) begin
                     res_ff   <= 1'b0;
                     state_ff <= DONE;
                  end else if (cand_n == W'(2)) begin
                     res_ff   <= 1'b1;
                     state_ff <= DONE;
                  end else if (!cand_n[0]) begin
                     res_ff   <= 1'b0;
                     state_ff <= DONE;
                  end else begin
                     state_ff <= SPLIT;
                  end
               end
            end
            SPLIT: begin
               // strip trailing zeros of n-1, one per cycle
               if (!d_ff[0]) begin
                  d_ff <= d_ff >> 1;
                  r_ff <= r_ff + RW'(1);
               end else begin
                  state_ff <= BASE_SEL;
               end
            end
            BASE_SEL: begin
               if (base_w == n_ff) begin
                  // base is a multiple of n: skip it
                  if (last_base) begin
                     res_ff   <= 1'b1;
                     state_ff <= DONE;
                  end else begin
                     i_ff <= i_ff + IW'(1);
                  end
               end else begin
                  sq_ff    <= base_w;
                  state_ff <= REDUCE;
               end
            end
            REDUCE: begin
               // bring the base below n for small n
               if (sq_ff >= n_ff) begin
                  sq_ff <= sq_ff - n_ff;
               end else begin
                  acc_ff   <= W'(1);
                  e_ff     <= d_ff;
                  state_ff <= POW_STEP;
               end
            end
            POW_STEP: begin
               if (e_ff == '0) begin
                  x_ff     <= acc_ff;
                  state_ff <= CHECK;
               end else if (e_ff[0]) begin
                  mul_a_ff     <= acc_ff;
                  mul_b_ff     <= sq_ff;
                  mul_start_ff <= 1'b1;
                  state_ff     <= POW_ACC_WAIT;
               end else begin
                  mul_a_ff     <= sq_ff;
                  mul_b_ff     <= sq_ff;
                  mul_start_ff <= 1'b1;
                  state_ff     <= POW_SQ_WAIT;
               end
            end
            POW_ACC_WAIT: begin
               if (mul_done) begin
                  acc_ff       <= product;
                  mul_a_ff     <= sq_ff;
                  mul_b_ff     <= sq_ff;
                  mul_start_ff <= 1'b1;
                  state_ff     <= POW_SQ_WAIT;
               end
            end
            POW_SQ_WAIT: begin
               if (mul_done) begin
                  sq_ff    <= product;
                  e_ff     <= e_ff >> 1;
                  state_ff <= POW_STEP;
               end
            end
            CHECK: begin
               if (x_ff == W'(1) || x_ff == nm1_ff) begin
                  if (last_base) begin
                     res_ff   <= 1'b1;
                     state_ff <= DONE;
                  end else begin
                     i_ff     <= i_ff + IW'(1);
                     state_ff <= BASE_SEL;
                  end
               end else begin
                  k_ff     <= RW'(1);
                  state_ff <= SQ_CHECK;
               end
            end
            SQ_CHECK: begin
               if (k_ff < r_ff) begin
                  mul_a_ff     <= x_ff;
                  mul_b_ff     <= x_ff;
                  mul_start_ff <= 1'b1;
                  k_ff         <= k_ff + RW'(1);
                  state_ff     <= SQ_WAIT;
               end else begin
                  // witness found: composite
                  res_ff   <= 1'b0;
                  state_ff <= DONE;
               end
            end
            SQ_WAIT: begin
               if (mul_done) begin
                  x_ff <= product;
                  if (product == nm1_ff) begin
                     if (last_base) begin
                        res_ff   <= 1'b1;
                        state_ff <= DONE;
                     end else begin
                        i_ff     <= i_ff + IW'(1);
                        state_ff <= BASE_SEL;
                     end
                  end else begin
                     state_ff <= SQ_CHECK;
                  end
               end
            end
            DONE: begin
               // hold until the output register is free
               if (!rsp_valid_ff || rsp_if.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_prime_ff <= res_ff;
                  state_ff     <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == POW_ACC_WAIT || state_ff == POW_SQ_WAIT ||
                    state_ff == SQ_WAIT))
      else $error("product arrived outside a wait state");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> (state_ff != IDLE))
      else $error("accepted transaction did not start work");

   a_sq_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == POW_STEP) |-> (sq_ff < n_ff && acc_ff < n_ff))
      else $error("operand not reduced below n");

   a_start_needs_odd_n: assert property (@(posedge clock) disable iff (reset)
      mul_start_ff |-> (n_ff[0] && n_ff > W'(2)))
      else $error("product started for trivial candidate");
`endif

endmodule
`default_nettype wire

[test/mrpt_checker.sv]
`timescale 1ns / 100ps
module mrpt_checker #(
   parameter int unsigned NUM_WIDTH = 63,
   parameter int unsigned NUM_BASES = 12
) (
   input  wire logic   clock,
   input  wire logic   reset,
   mrpt_req_if         req_if,
   mrpt_rsp_if         rsp_if,
   output int unsigned fail_count,
   output int unsigned pending
);

   localparam logic [63:0] WITNESS [12] = '{64'd2, 64'd3, 64'd5, 64'd7, 64'd11, 64'd13,
                                            64'd17, 64'd19, 64'd23, 64'd29, 64'd31, 64'd37};

   bit verdict_queue [$];

   // (a*b) mod n by shift-add; both addends stay below 2^63
   function automatic logic [63:0] residue_product(input logic [63:0] a, input logic [63:0] b,
                                                   input logic [63:0] n);
      logic [63:0] acc;
      logic [63:0] addend;
      logic [63:0] mult;
      acc    = 64'd0;
      addend = a % n;
      mult   = b;
      while (mult != 64'd0) begin
         if (mult[0]) acc = (acc + addend) % n;
         addend = (addend << 1) % n;
         mult   = mult >> 1;
      end
      return acc;
   endfunction

   function automatic logic [63:0] residue_power(input logic [63:0] b, input logic [63:0] e,
                                                 input logic [63:0] n);
      logic [63:0] acc;
      logic [63:0] sq;
      logic [63:0] ex;
      acc = 64'd1 % n;
      sq  = b % n;
      ex  = e;
      while (ex != 64'd0) begin
         if (ex[0]) acc = residue_product(acc, sq, n);
         sq = residue_product(sq, sq, n);
         ex = ex >> 1;
      end
      return acc;
   endfunction

   function automatic bit strong_prime_verdict(input logic [62:0] cand);
      logic [63:0] n;
      logic [63:0] nm1;
      logic [63:0] odd_part;
      logic [63:0] x;
      int unsigned twos;
      bit ok;
      n = 64'(cand) & ((64'd1 << NUM_WIDTH) - 64'd1);
      if (n < 64'd2) return 1'b0;
      if (n == 64'd2) return 1'b1;
      if (!n[0]) return 1'b0;
      nm1      = n - 64'd1;
      odd_part = nm1;
      twos     = 0;
      while (!odd_part[0]) begin
         odd_part = odd_part >> 1;
         twos++;
      end
      for (int i = 0; i < NUM_BASES && i < 12; i++) begin
         if (WITNESS[i] % n == 64'd0) continue;
         x  = residue_power(WITNESS[i], odd_part, n);
         ok = (x == 64'd1) || (x == nm1);
         for (int k = 1; !ok && k < twos; k++) begin
            x = residue_product(x, x, n);
            if (x == nm1) ok = 1'b1;
         end
         if (!ok) return 1'b0;
      end
      return 1'b1;
   endfunction

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   always @(posedge clock) begin
      bit want;
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            verdict_queue.push_back(strong_prime_verdict(req_if.candidate));
         if (rsp_if.valid && rsp_if.ready) begin
            if (verdict_queue.size() == 0) begin
               $error("prime_flag: expected none, actual %0d", rsp_if.prime_flag);
               fail_count <= fail_count + 1;
            end else begin
               want = verdict_queue.pop_front();
               if (rsp_if.prime_flag !== want) begin
                  $error("prime_flag: expected %0d, actual %0d", want, rsp_if.prime_flag);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= verdict_queue.size();
      end
   end

endmodule

[test/tb_miller_rabin_prime_test.sv]
`timescale 1ns / 100ps
module tb_miller_rabin_prime_test;

   // Allow every item the cost of the worst odd candidate and then some.
   localparam longint unsigned CYCLE_LIMIT = 64'd60_000_000;
   localparam int unsigned     RANDOM_ITEMS = 80;
   localparam int unsigned     HOLD_CYCLES  = 3000;

   logic        clock;
   logic        reset;
   bit          quiet;          // no idling on either side while set
   int unsigned fail_count;
   int unsigned pending;
   longint unsigned cycle_count;

   mrpt_req_if req_if();
   mrpt_rsp_if rsp_if();

   miller_rabin_prime_test u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   mrpt_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .rsp_if     (rsp_if),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Abort a hung run.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Offer one candidate and hold it until the block takes the transaction.
   task automatic offer_candidate(input logic [62:0] cand);
      while (!quiet && $urandom_range(99) < 25) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.candidate <= cand;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // Mostly small odd values so each test stays short; some full-width noise too.
   function automatic logic [62:0] random_candidate();
      int unsigned pick;
      int unsigned bits;
      logic [62:0] v;
      pick = $urandom_range(99);
      v    = 63'({$urandom, $urandom});
      if (pick < 55) begin
         bits = $urandom_range(20, 6);
         v    = (v & ((63'd1 << bits) - 63'd1)) | 63'd1;
      end else if (pick < 70) begin
         v = v & 63'd63;
      end else if (pick < 85) begin
         bits = $urandom_range(40, 8);
         v    = v & ((63'd1 << bits) - 63'd1);
      end
      return v;
   endfunction

   // Receiver: random stalls, plus one long hold-off on the first result so the
   // block fills up and the sender sees req ready drop.
   initial begin
      bit held;
      held = 1'b0;
      rsp_if.ready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!held && rsp_if.valid) begin
            held = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_if.ready <= quiet || ($urandom_range(99) >= 25);
      end
   end

   initial begin
      logic [62:0] directed [$];
      directed = '{63'd0, 63'd1, 63'd2, 63'd3, 63'd4, 63'd5, 63'd9, 63'd37, 63'd41,
                   63'd91, 63'd561, 63'd2047, 63'd3215031751,
                   63'd3825123056546413051, 63'd2305843009213693951,
                   63'h7FFF_FFFF_FFFF_FFE7, 63'h7FFF_FFFF_FFFF_FFFF,
                   63'h7FFF_FFFF_FFFF_FFFE, 63'h4000_0000_0000_0000,
                   63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAB};
      quiet            = 1'b0;
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.candidate <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) offer_candidate(directed[i]);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         quiet = (i >= 40 && i < 60);
         offer_candidate(random_candidate());
      end
      quiet = 1'b0;
      req_if.valid <= 1'b0;

      // Let the checker see the last transaction, then drain.
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
